/* rtl/core/mhpq_pkg.sv */
// Package for the min-heap priority queue: sizes, payload structs, codes, FSM states.
// No dependencies.
`default_nettype none
package mhpq_pkg;
  localparam int CAPACITY  = 64;
  localparam int NAME_BITS = 64;
  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int EW        = NAME_BITS + 32;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_POP     = 2'd1,
    MODE_UPGRADE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key_name;
    logic signed [31:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        served_name;
    logic [63:0]        front_name;
    logic signed [31:0] front_priority;
    logic [6:0]         entry_total;
    logic               is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN_RD,
    S_DN_L,
    S_DN_CMP,
    S_SC_RD,
    S_SC_CMP,
    S_FRONT_RD,
    S_FRONT,
    S_OUT
  } state_t;

  // entry a strictly more urgent than entry b
  function automatic logic more_urgent(logic signed [31:0] pa, logic [NAME_BITS-1:0] na,
                                       logic signed [31:0] pb, logic [NAME_BITS-1:0] nb);
    if (pa != pb) return pa < pb;
    return na < nb;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/min_heap_priority_queue.sv */
// Top level of the min-heap priority queue: control sequencer around one heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
//  channel | ports                          | payload
//  input   | in_valid, in_stall, in_data    | mhpq_pkg::in_item_t
//  result  | out_valid, out_stall, out_data | mhpq_pkg::out_item_t
//
// One item at a time; every heap access is one read or write of the single RAM port.
// Insert: sift-up by level; pop: last entry to the root, then sift-down; upgrade: scan of
// every entry plus sift-up; clear: count zeroed. Each ends with front read and output.
// Reset empties the heap at once; the RAM is not cleared.
// A held result blocks intake until it transfers.
`default_nettype none
module min_heap_priority_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mhpq_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mhpq_pkg::out_item_t       out_data
);
  localparam int NB = mhpq_pkg::NAME_BITS;
  localparam int AW = mhpq_pkg::AW;
  localparam int CW = mhpq_pkg::CW;

  mhpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;     // 1-based
  logic [CW-1:0]   chi_r, chi_nxt;     // 1-based child or scan index
  logic [1:0]      mode_r, mode_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [NB-1:0]   nm_r, nm_nxt;
  logic signed [31:0] pr_r, pr_nxt;
  logic [NB-1:0]   served_r, served_nxt;
  logic [NB-1:0]   ln_r, ln_nxt;       // left child / best found
  logic signed [31:0] lp_r, lp_nxt;
  logic            fnd_r, fnd_nxt;
  logic [CW-1:0]   wh_r, wh_nxt;
  mhpq_pkg::out_item_t out_r, out_nxt;
  logic            ov_r, ov_nxt;

  logic            we;
  logic [CW-1:0]   addr1;
  logic [mhpq_pkg::EW-1:0] wdata, rdata;
  logic [NB-1:0]   rn;
  logic signed [31:0] rp;

  assign rn = rdata[mhpq_pkg::EW-1 -: NB];
  assign rp = rdata[31:0];

  mhpq_ram #(.WIDTH(mhpq_pkg::EW), .DEPTH(mhpq_pkg::CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(AW'(addr1 - CW'(1))), .wdata(wdata), .rdata(rdata)
  );

  assign in_stall  = (state_r != mhpq_pkg::S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    pos_r <= pos_nxt; chi_r <= chi_nxt; mode_r <= mode_nxt; stat_r <= stat_nxt;
    nm_r <= nm_nxt; pr_r <= pr_nxt; served_r <= served_nxt; ln_r <= ln_nxt;
    lp_r <= lp_nxt; fnd_r <= fnd_nxt; wh_r <= wh_nxt; out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; chi_nxt = chi_r;
    mode_nxt = mode_r; stat_nxt = stat_r; nm_nxt = nm_r; pr_nxt = pr_r;
    served_nxt = served_r; ln_nxt = ln_r; lp_nxt = lp_r; fnd_nxt = fnd_r;
    wh_nxt = wh_r; out_nxt = out_r; ov_nxt = ov_r;
    we = 1'b0; addr1 = pos_r; wdata = {nm_r, pr_r};
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (in_valid && !ov_r) begin
          mode_nxt = in_data.mode; nm_nxt = in_data.key_name[NB-1:0];
          pr_nxt = in_data.item_priority; stat_nxt = mhpq_pkg::ST_OK;
          served_nxt = '0; fnd_nxt = 1'b0;
          case (mhpq_pkg::mode_t'(in_data.mode))
            mhpq_pkg::MODE_INSERT: begin
              if (cnt_r == CW'(mhpq_pkg::CAPACITY)) begin
                stat_nxt = mhpq_pkg::ST_FULL; state_nxt = mhpq_pkg::S_FRONT_RD;
              end else begin
                cnt_nxt = cnt_r + CW'(1); pos_nxt = cnt_r + CW'(1);
                state_nxt = mhpq_pkg::S_UP_RD;
              end
            end
            mhpq_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                stat_nxt = mhpq_pkg::ST_EMPTY; state_nxt = mhpq_pkg::S_FRONT_RD;
              end else state_nxt = mhpq_pkg::S_POP_RD;
            end
            mhpq_pkg::MODE_UPGRADE: begin
              chi_nxt = CW'(1); state_nxt = mhpq_pkg::S_SC_RD;
            end
            default: begin
              cnt_nxt = '0; state_nxt = mhpq_pkg::S_FRONT_RD;
            end
          endcase
        end
      end
      mhpq_pkg::S_UP_RD: begin
        if (pos_r == CW'(1)) begin
          we = 1'b1; state_nxt = mhpq_pkg::S_FRONT_RD;
        end else begin
          addr1 = pos_r >> 1; state_nxt = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        we = 1'b1;
        if (mhpq_pkg::more_urgent(pr_r, nm_r, rp, rn)) begin
          wdata = rdata; pos_nxt = pos_r >> 1; state_nxt = mhpq_pkg::S_UP_RD;
        end else state_nxt = mhpq_pkg::S_FRONT_RD;
      end
      mhpq_pkg::S_POP_RD: begin
        addr1 = CW'(1); state_nxt = mhpq_pkg::S_POP_LAST;
      end
      mhpq_pkg::S_POP_LAST: begin
        served_nxt = rn; addr1 = cnt_r; state_nxt = mhpq_pkg::S_DN_RD;
        cnt_nxt = cnt_r - CW'(1); pos_nxt = CW'(1); chi_nxt = '0;
      end
      mhpq_pkg::S_DN_RD: begin
        if (chi_r == '0) begin
          nm_nxt = rn; pr_nxt = rp;
        end
        if (cnt_r == '0) state_nxt = mhpq_pkg::S_FRONT_RD;
        else if ({pos_r, 1'b0} > {1'b0, cnt_r}) begin
          we = 1'b1; wdata = (chi_r == '0) ? rdata : {nm_r, pr_r};
          state_nxt = mhpq_pkg::S_FRONT_RD;
        end else begin
          addr1 = CW'({pos_r, 1'b0}); chi_nxt = CW'({pos_r, 1'b0});
          state_nxt = mhpq_pkg::S_DN_L;
        end
      end
      mhpq_pkg::S_DN_L: begin
        ln_nxt = rn; lp_nxt = rp;
        if (chi_r == cnt_r) state_nxt = mhpq_pkg::S_DN_CMP;
        else begin
          addr1 = chi_r + CW'(1); state_nxt = mhpq_pkg::S_DN_CMP;
          chi_nxt = chi_r + CW'(1);
        end
      end
      mhpq_pkg::S_DN_CMP: begin
        // chi_r is odd when the right child was read into rdata
        logic [NB-1:0] cn; logic signed [31:0] cp; logic [CW-1:0] ci;
        cn = ln_r; cp = lp_r; ci = chi_r;
        if (chi_r[0]) begin
          if (mhpq_pkg::more_urgent(rp, rn, lp_r, ln_r)) begin
            cn = rn; cp = rp;
          end else ci = chi_r - CW'(1);
        end
        we = 1'b1;
        if (mhpq_pkg::more_urgent(cp, cn, pr_r, nm_r)) begin
          wdata = {cn, cp}; pos_nxt = ci; state_nxt = mhpq_pkg::S_DN_RD;
        end else state_nxt = mhpq_pkg::S_FRONT_RD;
      end
      mhpq_pkg::S_SC_RD: begin
        if (chi_r > cnt_r) begin
          if (!fnd_r || !(pr_r < lp_r)) begin
            stat_nxt = mhpq_pkg::ST_REJECTED; state_nxt = mhpq_pkg::S_FRONT_RD;
          end else begin
            pos_nxt = wh_r; state_nxt = mhpq_pkg::S_UP_RD;
          end
        end else begin
          addr1 = chi_r; state_nxt = mhpq_pkg::S_SC_CMP;
        end
      end
      mhpq_pkg::S_SC_CMP: begin
        if (rn == nm_r && (!fnd_r || rp < lp_r)) begin
          fnd_nxt = 1'b1; lp_nxt = rp; wh_nxt = chi_r;
        end
        chi_nxt = chi_r + CW'(1); state_nxt = mhpq_pkg::S_SC_RD;
      end
      mhpq_pkg::S_FRONT_RD: begin
        addr1 = CW'(1); state_nxt = mhpq_pkg::S_FRONT;
      end
      mhpq_pkg::S_FRONT: begin
        out_nxt.status = stat_r; out_nxt.served_name = 64'(served_r);
        out_nxt.front_name = (cnt_r == '0) ? '0 : 64'(rn);
        out_nxt.front_priority = (cnt_r == '0) ? '0 : rp;
        out_nxt.entry_total = 7'(cnt_r); out_nxt.is_empty = (cnt_r == '0);
        ov_nxt = 1'b1; state_nxt = mhpq_pkg::S_OUT;
      end
      mhpq_pkg::S_OUT: state_nxt = mhpq_pkg::S_IDLE;
      default: state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(mhpq_pkg::CAPACITY)) else $error("count over capacity");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mhpq_pkg::S_IDLE) |-> in_stall) else $error("intake while busy");
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (out_r.is_empty == (out_r.entry_total == 7'd0))) else $error("empty flag");
  a_served: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.status != mhpq_pkg::ST_OK) |-> out_r.served_name == '0)
    else $error("served name on failure");
`endif
endmodule
`default_nettype wire

/* rtl/core/mhpq_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for min_heap_priority_queue: directed and random heap operations
// checked against an in-bench heap predictor. Depends on mhpq_pkg and the RTL.
module tb_top;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mhpq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mhpq_pkg::out_item_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  logic [63:0] heap_name [1:mhpq_pkg::CAPACITY];
  logic signed [31:0] heap_prio [1:mhpq_pkg::CAPACITY];
  int heap_count = 0;
  mhpq_pkg::out_item_t expected_q[$];

  min_heap_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit ahead(logic signed [31:0] pa, logic [63:0] na,
                               logic signed [31:0] pb, logic [63:0] nb);
    if (pa != pb) return pa < pb;
    return na < nb;
  endfunction

  function automatic void heap_sift_up(int pos, logic signed [31:0] p, logic [63:0] n);
    while (pos > 1 && ahead(p, n, heap_prio[pos/2], heap_name[pos/2])) begin
      heap_prio[pos] = heap_prio[pos/2];
      heap_name[pos] = heap_name[pos/2];
      pos = pos / 2;
    end
    heap_prio[pos] = p;
    heap_name[pos] = n;
  endfunction

  function automatic void heap_sift_down(logic signed [31:0] p, logic [63:0] n);
    int pos;
    int c;
    pos = 1;
    while (pos * 2 <= heap_count) begin
      c = pos * 2;
      if (c != heap_count && ahead(heap_prio[c+1], heap_name[c+1], heap_prio[c], heap_name[c]))
        c++;
      if (!ahead(heap_prio[c], heap_name[c], p, n)) break;
      heap_prio[pos] = heap_prio[c];
      heap_name[pos] = heap_name[c];
      pos = c;
    end
    heap_prio[pos] = p;
    heap_name[pos] = n;
  endfunction

  function automatic mhpq_pkg::out_item_t heap_apply(mhpq_pkg::in_item_t it);
    mhpq_pkg::out_item_t r;
    bit found;
    logic signed [31:0] best;
    int where;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    case (mhpq_pkg::mode_t'(it.mode))
      mhpq_pkg::MODE_INSERT: begin
        if (heap_count >= mhpq_pkg::CAPACITY) r.status = mhpq_pkg::ST_FULL;
        else begin
          heap_count++;
          heap_sift_up(heap_count, it.item_priority, it.key_name);
        end
      end
      mhpq_pkg::MODE_POP: begin
        if (heap_count == 0) r.status = mhpq_pkg::ST_EMPTY;
        else begin
          r.served_name = heap_name[1];
          heap_count--;
          if (heap_count > 0) heap_sift_down(heap_prio[heap_count+1], heap_name[heap_count+1]);
        end
      end
      mhpq_pkg::MODE_UPGRADE: begin
        found = 1'b0;
        best = 0;
        where = 0;
        for (int i = 1; i <= heap_count; i++)
          if (heap_name[i] == it.key_name && (!found || heap_prio[i] < best)) begin
            found = 1'b1;
            best = heap_prio[i];
            where = i;
          end
        if (!found || best <= it.item_priority) r.status = mhpq_pkg::ST_REJECTED;
        else heap_sift_up(where, it.item_priority, it.key_name);
      end
      default: heap_count = 0;
    endcase
    if (heap_count > 0) begin
      r.front_name = heap_name[1];
      r.front_priority = heap_prio[1];
    end
    r.entry_total = 7'(heap_count);
    r.is_empty = (heap_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_item(logic [1:0] mode, logic [63:0] key, logic signed [31:0] prio);
    mhpq_pkg::in_item_t it;
    it.mode = mode;
    it.key_name = key;
    it.item_priority = prio;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(heap_apply(it));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    mhpq_pkg::out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0)
        report_mismatch("unexpected transfer", out_data.front_name, '0);
      else begin
        w = expected_q.pop_front();
        if (out_data.status != w.status) report_mismatch("status", out_data.status, w.status);
        if (out_data.served_name != w.served_name)
          report_mismatch("served_name", out_data.served_name, w.served_name);
        if (out_data.front_name != w.front_name)
          report_mismatch("front_name", out_data.front_name, w.front_name);
        if (out_data.front_priority != w.front_priority)
          report_mismatch("front_priority", out_data.front_priority, w.front_priority);
        if (out_data.entry_total != w.entry_total)
          report_mismatch("entry_total", out_data.entry_total, w.entry_total);
        if (out_data.is_empty != w.is_empty)
          report_mismatch("is_empty", out_data.is_empty, w.is_empty);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] pick_name();
    case ($urandom_range(3))
      0: return 64'(8'h41 + $urandom_range(7)) << 56;
      1: return 64'h0;
      2: return {$urandom, $urandom};
      default: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_prio();
    case ($urandom_range(4))
      0: return 32'sh8000_0000 + $urandom_range(3);
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return $signed(32'($urandom_range(8))) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(mhpq_pkg::MODE_POP, 0, 0);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'h4100_0000_0000_0000, -5);
    send_item(mhpq_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
    send_item(mhpq_pkg::MODE_INSERT, 64'h0, 32'sh8000_0000);
    send_item(mhpq_pkg::MODE_INSERT, 64'h4200_0000_0000_0000, 0);
    send_item(mhpq_pkg::MODE_INSERT, 64'h4100_0000_0000_0000, 0);
    send_item(mhpq_pkg::MODE_INSERT, 64'h4100_0000_0000_0000, 7);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'h4100_0000_0000_0000, 0);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'h4100_0000_0000_0000, 1);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'h4100_0000_0000_0000, -1);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'h5A00_0000_0000_0000, -9);
    send_item(mhpq_pkg::MODE_UPGRADE, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh8000_0000);
    repeat (3) send_item(mhpq_pkg::MODE_POP, 0, 0);
    send_item(mhpq_pkg::MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, -1);
    send_item(mhpq_pkg::MODE_POP, 0, 0);
  endtask

  task automatic test_full();
    for (int i = 0; i < mhpq_pkg::CAPACITY + 2; i++)
      send_item(mhpq_pkg::MODE_INSERT, pick_name(), pick_prio());
    send_item(mhpq_pkg::MODE_UPGRADE, pick_name(), pick_prio());
    repeat (4) send_item(mhpq_pkg::MODE_POP, 0, 0);
    send_item(mhpq_pkg::MODE_CLEAR, 0, 0);
  endtask

  task automatic test_random(int n);
    int r;
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) m = mhpq_pkg::MODE_INSERT;
      else if (r < 75) m = mhpq_pkg::MODE_POP;
      else if (r < 98) m = mhpq_pkg::MODE_UPGRADE;
      else m = mhpq_pkg::MODE_CLEAR;
      if (m == mhpq_pkg::MODE_UPGRADE && heap_count > 0 && $urandom_range(3) != 0)
        send_item(m, heap_name[$urandom_range(heap_count, 1)], pick_prio());
      else send_item(m, pick_name(), pick_prio());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full();
    test_random(200);
    send_idle_pct = 64;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    test_random(150);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(100);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
